// ===== design/sbm_pkg.sv =====
// ============================================================================
// Spectrum band mapper package
// Shared sizes, payload types, controller commands and the band edge table.
// ============================================================================
`default_nettype none

package sbm_pkg;

    localparam int NUM_BINS   = 256;
    localparam int NUM_BANDS  = 75;
    localparam int MAX_OUT    = 4;

    localparam int IN_W       = 24;
    localparam int MAG_W      = 32;
    localparam int GAIN_W     = 16;
    localparam int LEVEL_W    = 8;
    localparam int BANDNUM_W  = 7;
    localparam int FRAC_W     = 8;
    localparam int WGT_W      = FRAC_W + 1;

    localparam int ADDR_W     = $clog2(NUM_BINS);
    localparam int EDGE_W     = $clog2(NUM_BINS * 256 + 1);
    localparam int IDX_W      = EDGE_W - FRAC_W;
    localparam int BAND_W     = $clog2(NUM_BANDS + 1);
    localparam int EMIT_W     = $clog2(MAX_OUT + 1);

    localparam int SQ_W       = 2 * IN_W;
    localparam int RAD_W      = 64;
    localparam int SQRT_STEPS = RAD_W / 2;
    localparam int STEP_W     = $clog2(SQRT_STEPS);

    localparam int HERM_W     = 64;
    localparam int HQ_W       = HERM_W - 25;
    localparam int ACC_W      = MAG_W + WGT_W + IDX_W + 2;

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(2048);

    // Q16 mantissa of 2^(r/12), r = 0..11, from the quadratic fit
    // 0.66023 f + 0.33977 f^2 with ties rounded up.
    localparam longint unsigned MANT_Q16 [0:11] = '{
        64'd65536,
        64'd65536 + (64'd65536 * 64'd826253 + 64'd7200000) / 64'd14400000,
        64'd65536 + (64'd65536 * 64'd1720460 + 64'd7200000) / 64'd14400000,
        64'd65536 + (64'd65536 * 64'd2682621 + 64'd7200000) / 64'd14400000,
        64'd65536 + (64'd65536 * 64'd3712736 + 64'd7200000) / 64'd14400000,
        64'd65536 + (64'd65536 * 64'd4810805 + 64'd7200000) / 64'd14400000,
        64'd65536 + (64'd65536 * 64'd5976828 + 64'd7200000) / 64'd14400000,
        64'd65536 + (64'd65536 * 64'd7210805 + 64'd7200000) / 64'd14400000,
        64'd65536 + (64'd65536 * 64'd8512736 + 64'd7200000) / 64'd14400000,
        64'd65536 + (64'd65536 * 64'd9882621 + 64'd7200000) / 64'd14400000,
        64'd65536 + (64'd65536 * 64'd11320460 + 64'd7200000) / 64'd14400000,
        64'd65536 + (64'd65536 * 64'd12826253 + 64'd7200000) / 64'd14400000
    };

    typedef struct packed {
        logic signed [IN_W-1:0] bin_first;
        logic signed [IN_W-1:0] bin_second;
    } in_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]   band_level;
        logic [BANDNUM_W-1:0] band_number;
        logic                 last_band;
    } out_t;

    typedef struct packed {
        logic [IDX_W-1:0]  first;
        logic [IDX_W-1:0]  last_bin;
        logic [IDX_W-1:0]  need;
        logic [FRAC_W-1:0] frac;
        logic [WGT_W-1:0]  mult;
        logic [WGT_W-1:0]  last_w;
    } band_info_t;

    typedef struct packed {
        logic                 ld_in;
        logic                 sq_a;
        logic                 sq_b;
        logic                 sqrt_step;
        logic                 wr_en;
        logic [ADDR_W-1:0]    wr_addr;
        logic                 rd_en;
        logic [ADDR_W-1:0]    rd_addr;
        logic                 rd_zero;
        logic                 cap_y;
        logic [1:0]           y_sel;
        logic                 herm_coef;
        logic                 herm_step;
        logic [1:0]           herm_sel;
        logic                 herm_round;
        logic                 acc_init;
        logic                 acc_add;
        logic [WGT_W-1:0]     weight;
        logic [FRAC_W-1:0]    frac;
        logic                 out_load;
        logic [BANDNUM_W-1:0] band_number;
        logic                 last_band;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    typedef logic [EDGE_W-1:0] edge_tab_t [0:NUM_BANDS];

    // Q16 value of 2^(x/12): the octave count comes from repeated subtraction.
    function automatic longint unsigned sapow_q16(input int unsigned x);
        int unsigned r;
        int unsigned sh;
        r  = x;
        sh = 0;
        while (r >= 12) begin
            r  = r - 12;
            sh = sh + 1;
        end
        return MANT_Q16[r] << sh;
    endfunction

    // Unsigned quotient by restoring long division, used only at elaboration.
    function automatic longint unsigned udiv64(input longint unsigned n,
                                               input longint unsigned d);
        longint unsigned q;
        longint unsigned rem;
        q   = 0;
        rem = 0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], n[i]};
            if (rem >= d) begin
                rem  = rem - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic edge_tab_t build_edges();
        edge_tab_t       tab;
        longint unsigned top;
        longint unsigned num;
        top = sapow_q16(NUM_BANDS);
        for (int x = 0; x <= NUM_BANDS; x++) begin
            num    = (sapow_q16(x) - 65536) * longint'(NUM_BINS - 1) * 256;
            tab[x] = EDGE_W'(256 + udiv64(num + (top >> 1), top));
        end
        return tab;
    endfunction

    localparam edge_tab_t EDGE_TAB = build_edges();

    // Bin range, readiness point and edge weights of one band.
    function automatic band_info_t band_info(input logic [BAND_W-1:0] b);
        band_info_t        bi;
        logic [EDGE_W-1:0] e0;
        logic [EDGE_W-1:0] e1;
        logic [IDX_W-1:0]  last_raw;
        logic [IDX_W-1:0]  need;
        e0       = EDGE_TAB[b];
        e1       = EDGE_TAB[BAND_W'(b + 1'b1)];
        bi.first = e0[EDGE_W-1:FRAC_W];
        last_raw = e1[EDGE_W-1:FRAC_W];
        bi.last_bin = (last_raw > IDX_W'(NUM_BINS - 1)) ? IDX_W'(NUM_BINS - 1) : last_raw;
        need = bi.first + IDX_W'(2);
        if (need < bi.last_bin) begin
            need = bi.last_bin;
        end
        if (need > IDX_W'(NUM_BINS - 1)) begin
            need = IDX_W'(NUM_BINS - 1);
        end
        bi.need   = need;
        bi.frac   = e0[FRAC_W-1:0];
        bi.mult   = (bi.first == bi.last_bin) ? WGT_W'(e1 - e0)
                                              : WGT_W'(EDGE_W'(256) - EDGE_W'(e0[FRAC_W-1:0]));
        bi.last_w = WGT_W'(e1 - {bi.last_bin, {FRAC_W{1'b0}}});
        return bi;
    endfunction

endpackage

`default_nettype wire

// ===== design/spectrum_band_mapper.sv =====
// ============================================================================
// Spectrum band mapper
// Maps a frame of FFT bins onto log-spaced display bands.
// ============================================================================
// Each request on the s_ channel carries one FFT bin as two signed 24-bit
// components. The block forms the bin magnitude in Q8, scales it by the Q4.12
// gain register written over the cfg_ channel (reset value 0.5), and stores it
// in a 256-entry magnitude memory. After each request every display band whose
// bins have all arrived is computed and sent on the m_ channel, at most four
// per request, in band order; the remaining ready bands follow on later
// requests. A request that arrives after a full frame while bands are still
// pending only drains bands and is not stored. Sending the last band starts a
// new frame. A stored bin passes through a bit-serial square root that
// resolves one result bit per cycle. A band reads its bins one at a time
// through the single memory read port, and it can wait for the result
// register to be taken. The result register lets a band wait on
// m_ready while the next request is accepted. The gain may be written only
// while the block is idle; the cfg_ channel is always ready.
// ============================================================================
`default_nettype none

module spectrum_band_mapper (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire sbm_pkg::in_t               s_data,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output sbm_pkg::out_t                   m_data,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [sbm_pkg::GAIN_W-1:0] cfg_data
);
    import sbm_pkg::*;

    cmd_t    cmd;
    status_t status;

    // The gain register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    // Controller: sequences each request and each band.
    sbm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Datapath: magnitude, store, interpolation, accumulation and output.
    sbm_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_ready   (m_ready),
        .status    (status),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

// ===== design/sbm_ram.sv =====
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module sbm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/sbm_ctrl.sv =====
// ============================================================================
// Spectrum band mapper controller
// Sequences magnitude computation, store writes and per-band accumulation.
// ============================================================================
`default_nettype none

module sbm_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire sbm_pkg::status_t status,
    output sbm_pkg::cmd_t        cmd
);
    import sbm_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQA   = 4'd1;
    localparam logic [3:0] S_SQB   = 4'd2;
    localparam logic [3:0] S_SQRT  = 4'd3;
    localparam logic [3:0] S_GAIN  = 4'd4;
    localparam logic [3:0] S_CHK   = 4'd5;
    localparam logic [3:0] S_HRD   = 4'd6;
    localparam logic [3:0] S_HCAP  = 4'd7;
    localparam logic [3:0] S_HCOEF = 4'd8;
    localparam logic [3:0] S_HORN  = 4'd9;
    localparam logic [3:0] S_HRND  = 4'd10;
    localparam logic [3:0] S_HMUL  = 4'd11;
    localparam logic [3:0] S_SRD   = 4'd12;
    localparam logic [3:0] S_SCAP  = 4'd13;
    localparam logic [3:0] S_EMIT  = 4'd14;

    logic [3:0]        state_reg,     state_next;
    logic [IDX_W-1:0]  bin_cnt_reg,   bin_cnt_next;
    logic [BAND_W-1:0] band_reg,      band_next;
    logic [EMIT_W-1:0] emit_cnt_reg,  emit_cnt_next;
    logic [STEP_W-1:0] step_reg,      step_next;
    logic [IDX_W-1:0]  k_reg,         k_next;
    band_info_t        info_reg,      info_next;
    band_info_t        cur_info;
    logic [IDX_W:0]    herm_addr;
    logic              is_last_band;

    assign cur_info     = band_info(band_reg);
    assign herm_addr    = {1'b0, info_reg.first} + (IDX_W + 1)'(step_reg[1:0])
                          - (IDX_W + 1)'(1);
    assign is_last_band = (band_reg == BAND_W'(NUM_BANDS - 1));
    assign s_ready      = (state_reg == S_IDLE);

    always_comb begin
        state_next    = state_reg;
        bin_cnt_next  = bin_cnt_reg;
        band_next     = band_reg;
        emit_cnt_next = emit_cnt_reg;
        step_next     = step_reg;
        k_next        = k_reg;
        info_next     = info_reg;
        cmd           = '0;
        cmd.frac      = info_reg.frac;
        cmd.weight    = info_reg.mult;
        cmd.herm_sel  = step_reg[1:0];
        cmd.y_sel     = step_reg[1:0];
        cmd.band_number = BANDNUM_W'(band_reg);
        cmd.last_band   = is_last_band;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.ld_in     = 1'b1;
                    emit_cnt_next = '0;
                    state_next    = (bin_cnt_reg < IDX_W'(NUM_BINS)) ? S_SQA : S_CHK;
                end
            end
            S_SQA: begin
                cmd.sq_a   = 1'b1;
                state_next = S_SQB;
            end
            S_SQB: begin
                cmd.sq_b   = 1'b1;
                step_next  = '0;
                state_next = S_SQRT;
            end
            S_SQRT: begin
                cmd.sqrt_step = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == STEP_W'(SQRT_STEPS - 1)) begin
                    state_next = S_GAIN;
                end
            end
            S_GAIN: begin
                cmd.wr_en    = 1'b1;
                cmd.wr_addr  = bin_cnt_reg[ADDR_W-1:0];
                bin_cnt_next = bin_cnt_reg + 1'b1;
                state_next   = S_CHK;
            end
            S_CHK: begin
                if ((emit_cnt_reg < EMIT_W'(MAX_OUT)) && (cur_info.need < bin_cnt_reg)) begin
                    info_next  = cur_info;
                    step_next  = '0;
                    state_next = S_HRD;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_HRD: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = herm_addr[ADDR_W-1:0];
                cmd.rd_zero = (herm_addr >= (IDX_W + 1)'(NUM_BINS));
                state_next  = S_HCAP;
            end
            S_HCAP: begin
                cmd.cap_y = 1'b1;
                if (step_reg[1:0] == 2'd3) begin
                    state_next = S_HCOEF;
                end else begin
                    step_next  = step_reg + 1'b1;
                    state_next = S_HRD;
                end
            end
            S_HCOEF: begin
                cmd.herm_coef = 1'b1;
                step_next     = '0;
                state_next    = S_HORN;
            end
            S_HORN: begin
                cmd.herm_step = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg[1:0] == 2'd2) begin
                    state_next = S_HRND;
                end
            end
            S_HRND: begin
                cmd.herm_round = 1'b1;
                state_next     = S_HMUL;
            end
            S_HMUL: begin
                cmd.acc_init = 1'b1;
                k_next       = info_reg.first + 1'b1;
                state_next   = (info_reg.first == info_reg.last_bin) ? S_EMIT : S_SRD;
            end
            S_SRD: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = k_reg[ADDR_W-1:0];
                state_next  = S_SCAP;
            end
            S_SCAP: begin
                cmd.acc_add = 1'b1;
                if (k_reg == info_reg.last_bin) begin
                    cmd.weight = info_reg.last_w;
                    state_next = S_EMIT;
                end else begin
                    cmd.weight = WGT_W'(256);
                    k_next     = k_reg + 1'b1;
                    state_next = S_SRD;
                end
            end
            S_EMIT: begin
                if (status.out_free) begin
                    cmd.out_load  = 1'b1;
                    emit_cnt_next = emit_cnt_reg + 1'b1;
                    if (is_last_band) begin
                        band_next    = '0;
                        bin_cnt_next = '0;
                    end else begin
                        band_next = band_reg + 1'b1;
                    end
                    state_next = S_CHK;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            bin_cnt_reg  <= '0;
            band_reg     <= '0;
            emit_cnt_reg <= '0;
            step_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            bin_cnt_reg  <= bin_cnt_next;
            band_reg     <= band_next;
            emit_cnt_reg <= emit_cnt_next;
            step_reg     <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg    <= k_next;
        info_reg <= info_next;
    end

endmodule

`default_nettype wire

// ===== design/sbm_datapath.sv =====
// ============================================================================
// Spectrum band mapper datapath
// Magnitude unit, magnitude store, Hermite evaluator, band accumulator and
// the result register.
// ============================================================================
`default_nettype none

module sbm_datapath (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire sbm_pkg::cmd_t             cmd,
    input  wire sbm_pkg::in_t              s_data,
    input  wire logic                      cfg_valid,
    input  wire logic [sbm_pkg::GAIN_W-1:0] cfg_data,
    input  wire logic                      m_ready,
    output sbm_pkg::status_t               status,
    output logic                           m_valid,
    output sbm_pkg::out_t                  m_data
);
    import sbm_pkg::*;

    logic [GAIN_W-1:0]         gain_reg;
    logic [IN_W-1:0]           ua_reg, uc_reg;
    logic [SQ_W-1:0]           sqa_reg;
    logic [RAD_W-1:0]          n_reg, res_reg, bit_reg;
    logic [MAG_W-1:0]          y_reg [0:3];
    logic signed [HERM_W-1:0]  k1_reg, k2_reg, k3_reg, v_reg;
    logic signed [HQ_W-1:0]    hq_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic                      rd_zero_reg;
    logic                      m_valid_reg;
    out_t                      m_data_reg;

    logic [IN_W-1:0]           mul_in;
    logic [SQ_W-1:0]           sq;
    logic [SQ_W-1:0]           sq_sum;
    logic [RAD_W-1:0]          trial;
    logic [MAG_W+GAIN_W-1:0]   gprod;
    logic [MAG_W+GAIN_W:0]     grnd;
    logic [MAG_W-1:0]          wdata;
    logic [MAG_W-1:0]          rdata;
    logic [MAG_W-1:0]          rd_val;
    logic signed [HERM_W-1:0]  ys0, ys1, ys2, ys3, k1, k3;
    logic signed [HERM_W-1:0]  h_base, h_add, h_sum;
    logic signed [FRAC_W:0]    t_s;
    logic [MAG_W+WGT_W-1:0]    term;
    logic signed [ACC_W-1:0]   lsum;
    logic signed [ACC_W-17:0]  lv;
    logic [LEVEL_W-1:0]        level;

    function automatic logic [IN_W-1:0] abs_val(input logic signed [IN_W-1:0] x);
        return x[IN_W-1] ? (~x + 1'b1) : x;
    endfunction

    // Magnitude: one multiplier squares both components in turn.
    assign mul_in = cmd.sq_b ? uc_reg : ua_reg;
    assign sq     = mul_in * mul_in;
    assign sq_sum = sqa_reg + sq;
    assign trial  = res_reg + bit_reg;
    assign gprod  = res_reg[MAG_W-1:0] * gain_reg;
    assign grnd   = ({1'b0, gprod} + (MAG_W + GAIN_W + 1)'(2048)) >> 12;
    assign wdata  = (|grnd[MAG_W+GAIN_W:MAG_W]) ? {MAG_W{1'b1}} : grnd[MAG_W-1:0];

    sbm_ram #(
        .WIDTH (MAG_W),
        .DEPTH (NUM_BINS)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.wr_en),
        .waddr (cmd.wr_addr),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (cmd.rd_addr),
        .rdata (rdata)
    );

    assign rd_val = rd_zero_reg ? '0 : rdata;

    // Hermite coefficients.
    assign ys0 = signed'({{(HERM_W - MAG_W){1'b0}}, y_reg[0]});
    assign ys1 = signed'({{(HERM_W - MAG_W){1'b0}}, y_reg[1]});
    assign ys2 = signed'({{(HERM_W - MAG_W){1'b0}}, y_reg[2]});
    assign ys3 = signed'({{(HERM_W - MAG_W){1'b0}}, y_reg[3]});
    assign k1  = ys2 - ys0;
    assign k3  = (ys1 - ys2) + (ys1 - ys2) + (ys1 - ys2) + (ys3 - ys0);

    // Horner steps, one narrow multiply by the edge fraction per cycle.
    assign t_s = signed'({1'b0, cmd.frac});
    always_comb begin
        h_base = v_reg;
        h_add  = ys1 <<< 25;
        unique case (cmd.herm_sel)
            2'd0: begin
                h_base = k3_reg;
                h_add  = k2_reg <<< 8;
            end
            2'd1: begin
                h_add = k1_reg <<< 16;
            end
            default: begin
                h_add = ys1 <<< 25;
            end
        endcase
        h_sum = h_base * t_s + h_add;
    end

    assign term = rd_val * cmd.weight;

    // Level: round off 16 fractional bits and clamp to the display range.
    assign lsum = acc_reg + ACC_W'(32768);
    assign lv   = lsum[ACC_W-1:16];
    always_comb begin
        if (lv < 0) begin
            level = '0;
        end else if (lv > (ACC_W - 16)'(255)) begin
            level = LEVEL_W'(255);
        end else begin
            level = lv[LEVEL_W-1:0];
        end
    end

    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg    <= GAIN_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                gain_reg <= cfg_data;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_in) begin
            ua_reg <= abs_val(s_data.bin_first);
            uc_reg <= abs_val(s_data.bin_second);
        end
        if (cmd.sq_a) begin
            sqa_reg <= sq;
        end
        if (cmd.sq_b) begin
            n_reg   <= RAD_W'({sq_sum, 16'd0});
            res_reg <= '0;
            bit_reg <= RAD_W'(1) << (RAD_W - 2);
        end
        if (cmd.sqrt_step) begin
            if (n_reg >= trial) begin
                n_reg   <= n_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.rd_en) begin
            rd_zero_reg <= cmd.rd_zero;
        end
        if (cmd.cap_y) begin
            y_reg[cmd.y_sel] <= rd_val;
        end
        if (cmd.herm_coef) begin
            k1_reg <= k1;
            k3_reg <= k3;
            k2_reg <= ys0 + ys0 - ys1 - ys1 + k1 - k3;
        end
        if (cmd.herm_step) begin
            v_reg <= h_sum;
        end
        if (cmd.herm_round) begin
            hq_reg <= HQ_W'((v_reg + (HERM_W'(1) <<< 24)) >>> 25);
        end
        if (cmd.acc_init) begin
            acc_reg <= ACC_W'(hq_reg) * signed'(ACC_W'(cmd.weight));
        end else if (cmd.acc_add) begin
            acc_reg <= acc_reg + signed'(ACC_W'(term));
        end
        if (cmd.out_load) begin
            m_data_reg.band_level  <= level;
            m_data_reg.band_number <= cmd.band_number;
            m_data_reg.last_band   <= cmd.last_band;
        end
    end

endmodule

`default_nettype wire

// ===== design/sbm_checker.sv =====
// ============================================================================
// Spectrum band mapper checker
// Port-level properties of the bin and band result streams.
// ============================================================================
`default_nettype none

module sbm_port_checker (
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       s_valid,
    input wire logic                       s_ready,
    input wire sbm_pkg::in_t               s_data,
    input wire logic                       m_valid,
    input wire logic                       m_ready,
    input wire sbm_pkg::out_t              m_data
);
    import sbm_pkg::*;

    // A waiting bin request holds.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("bin request changed while waiting");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_band_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.band_number < BANDNUM_W'(NUM_BANDS))
        else $error("band number out of range");

    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last_band == (m_data.band_number == BANDNUM_W'(NUM_BANDS - 1))))
        else $error("last band flag does not match band number");

    // Bands leave in order: a band valid just after a taken non-last one is its successor.
    a_band_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last_band ##1 m_valid
        |-> m_data.band_number == BANDNUM_W'($past(m_data.band_number) + 1'b1))
        else $error("band sequence broken");

endmodule

bind spectrum_band_mapper sbm_port_checker u_sbm_checker (.*);

`default_nettype wire

// ===== sim/sbm_checker.sv =====
// ============================================================================
// Spectrum band mapper checker
// Watches the gain, bin and band channels, predicts every band level and
// compares each band leaving the block with the oldest prediction.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module sbm_checker
    import sbm_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire logic              s_ready,
    input  wire in_t               s_data,
    input  wire logic              m_valid,
    input  wire logic              m_ready,
    input  wire out_t              m_data,
    input  wire logic              cfg_valid,
    input  wire logic              cfg_ready,
    input  wire logic [GAIN_W-1:0] cfg_data,
    output int                     errors,
    output int                     pending
);

    logic [31:0]      mag_mem [0:NUM_BINS-1];
    int unsigned      band_edge [0:NUM_BANDS];
    int unsigned      bins_held;
    int unsigned      band_ptr;
    logic [GAIN_W-1:0] gain;
    out_t             expected_bands [$];

    // Log-spaced band edges in Q8, from a quadratic fit of the semitone
    // mantissa, ties rounded up.
    initial begin
        longint unsigned scale [0:NUM_BANDS];
        longint unsigned r;
        longint unsigned num;
        for (int x = 0; x <= NUM_BANDS; x++) begin
            r = x % 12;
            scale[x] = (65536 + (65536 * (792276 * r + 33977 * r * r) + 7200000) / 14400000)
                       << (x / 12);
        end
        for (int x = 0; x <= NUM_BANDS; x++) begin
            num = (scale[x] - 65536) * (NUM_BINS - 1) * 256;
            band_edge[x] = 256 + (2 * num + scale[NUM_BANDS]) / (2 * scale[NUM_BANDS]);
        end
    end

    function automatic longint unsigned root64(input longint unsigned n);
        longint unsigned q;
        longint unsigned cand;
        q = 0;
        for (int i = 31; i >= 0; i--) begin
            cand = q | (64'd1 << i);
            if (cand * cand <= n) begin
                q = cand;
            end
        end
        return q;
    endfunction

    function automatic longint mag_at(input int i);
        return (i >= 0 && i < NUM_BINS) ? longint'({32'd0, mag_mem[i]}) : 0;
    endfunction

    function automatic int unsigned last_bin_of(input int unsigned b);
        int unsigned e;
        e = band_edge[b + 1] >> 8;
        return (e > NUM_BINS - 1) ? NUM_BINS - 1 : e;
    endfunction

    function automatic int unsigned ready_point(input int unsigned b);
        int unsigned n;
        n = (band_edge[b] >> 8) + 2;
        if (n < last_bin_of(b)) begin
            n = last_bin_of(b);
        end
        return (n > NUM_BINS - 1) ? NUM_BINS - 1 : n;
    endfunction

    function automatic logic [LEVEL_W-1:0] predict_level(input int unsigned b);
        longint e0, e1, t, weight, y0, y1, y2, y3, k1, k2, k3, v, acc, lvl;
        int     first, stop;
        e0    = band_edge[b];
        e1    = band_edge[b + 1];
        first = int'(e0 >> 8);
        stop  = int'(last_bin_of(b));
        t     = e0 & 255;
        weight = (first == stop) ? e1 - e0 : 256 - t;
        y0 = mag_at(first - 1);
        y1 = mag_at(first);
        y2 = mag_at(first + 1);
        y3 = mag_at(first + 2);
        // Cubic Hermite through the four neighbors, evaluated at the edge.
        k1 = y2 - y0;
        k3 = 3 * (y1 - y2) + (y3 - y0);
        k2 = 2 * y0 - 2 * y1 + k1 - k3;
        v  = k3 * t * t * t + k2 * t * t * 256 + k1 * t * 65536 + y1 * 33554432;
        acc = ((v + 16777216) >>> 25) * weight;
        for (int k = first + 1; k <= stop; k++) begin
            acc += mag_at(k) * ((k == stop) ? e1 - longint'(k) * 256 : 256);
        end
        lvl = (acc + 32768) >>> 16;
        if (lvl < 0) begin
            lvl = 0;
        end
        if (lvl > 255) begin
            lvl = 255;
        end
        return LEVEL_W'(lvl);
    endfunction

    task automatic take_bin(input in_t d);
        longint          a, c;
        longint unsigned p;
        out_t            o;
        int              sent;
        sent = 0;
        if (bins_held < NUM_BINS) begin
            a = d.bin_first;
            c = d.bin_second;
            p = (root64(longint'(a * a + c * c) << 16) * gain + 2048) >> 12;
            mag_mem[bins_held] = (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
            bins_held++;
        end
        while (sent < MAX_OUT && band_ptr < NUM_BANDS && ready_point(band_ptr) < bins_held) begin
            o.band_level  = predict_level(band_ptr);
            o.band_number = BANDNUM_W'(band_ptr);
            o.last_band   = (band_ptr == NUM_BANDS - 1);
            expected_bands.push_back(o);
            sent++;
            band_ptr++;
        end
        if (band_ptr >= NUM_BANDS) begin
            band_ptr  = 0;
            bins_held = 0;
        end
    endtask

    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            bins_held <= 0;
            band_ptr  <= 0;
            gain      <= GAIN_RESET;
            errors    <= 0;
            expected_bands.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_bands.size() == 0) begin
                    if (errors < 10) begin
                        $display("unexpected band %0d level %0d", m_data.band_number,
                                 m_data.band_level);
                    end
                    errors <= errors + 1;
                end else begin
                    want = expected_bands.pop_front();
                    if (want !== m_data) begin
                        if (errors < 10) begin
                            $display("band mismatch: expected band %0d level %0d last %0b, got band %0d level %0d last %0b",
                                     want.band_number, want.band_level, want.last_band,
                                     m_data.band_number, m_data.band_level, m_data.last_band);
                        end
                        errors <= errors + 1;
                    end
                end
            end
            if (s_valid && s_ready) begin
                take_bin(s_data);
            end
            if (cfg_valid && cfg_ready) begin
                gain <= cfg_data;
            end
        end
    end

    assign pending = expected_bands.size();

endmodule

`default_nettype wire

// ===== sim/spectrum_band_mapper_tb.sv =====
// ============================================================================
// Spectrum band mapper testbench
// Streams frames of FFT bins through the mapper under several gain settings,
// with random idling on both channels and one long result stall; the checker
// predicts and compares every band.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module spectrum_band_mapper_tb;
    import sbm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    in_t               s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    out_t              m_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [GAIN_W-1:0] cfg_data = '0;
    int                errors;
    int                pending;
    int                cycles = 0;
    int                bins_sent = 0;
    bit                calm = 1'b0;

    always #5 aclk = ~aclk;

    spectrum_band_mapper dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    sbm_checker chk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("spectrum_band_mapper_tb: done, errors");
            $finish;
        end
    end

    // Result side. It stalls in short random bursts, and once, partway into
    // the run, it holds off for a long stretch while bins keep coming, so the
    // result register fills and the block has to stall its input.
    initial begin
        bit long_done;
        long_done = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!long_done && bins_sent >= 270) begin
                long_done = 1'b1;
                m_ready <= 1'b0;
                repeat (600) @(posedge aclk);
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // One bin component. Small values keep the levels inside the display
    // range; isolated large ones make spikes whose Hermite overshoot can
    // push a band sum below zero; full-range values exercise every bit.
    function automatic logic signed [IN_W-1:0] pick_component();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return IN_W'(int'($urandom_range(0, 800)) - 400);
            5:             return '0;
            6, 7:          return IN_W'($urandom);
            8:             return $urandom_range(0, 1) ? IN_W'(24'h7FFFFF) : IN_W'(24'h800000);
            default:       return IN_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
        endcase
    endfunction

    // Offer one bin and hold it until accepted. Valid stays high afterwards;
    // a gap, when drawn, lowers it in the following step.
    task automatic send_bin(input logic signed [IN_W-1:0] a, input logic signed [IN_W-1:0] b);
        s_valid           <= 1'b1;
        s_data.bin_first  <= a;
        s_data.bin_second <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bins_sent++;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++) begin
            send_bin(pick_component(), pick_component());
        end
    endtask

    // Let every predicted band come out, then allow the block to finish a
    // bin that produces no band before the gain changes.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_gain(input logic [GAIN_W-1:0] g);
        cfg_valid <= 1'b1;
        cfg_data  <= g;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed bins at the reset gain: zero, both extremes, mixed signs,
        // single-bit values and a lone spike between quiet bins.
        send_bin(24'sd0, 24'sd0);
        send_bin(24'sh7FFFFF, 24'sh7FFFFF);
        send_bin(24'sh800000, 24'sh800000);
        send_bin(24'sh7FFFFF, 24'sh800000);
        send_bin(24'sh800000, 24'sd0);
        send_bin(24'sd1, 24'sd0);
        send_bin(24'sd0, -24'sd1);
        send_bin(24'sd3, 24'sd4);
        send_bin(-24'sd300, 24'sd200);
        send_bin(24'sd0, 24'sd0);
        send_bin(24'sd40000, 24'sd0);
        send_bin(24'sd0, 24'sd0);
        send_bin(24'sd0, 24'sd0);
        send_bin(24'sd100, -24'sd100);
        send_bin(-24'sd255, -24'sd255);
        send_bin(24'sh555555, 24'shAAAAAA);
        send_bin(24'shAAAAAA, 24'sh555555);
        send_bin(24'sd0, 24'sd0);
        send_bin(24'sd20, 24'sd0);
        send_bin(24'sd0, 24'sd20);
        send_random(100);
        settle();

        write_gain(16'hFFFF);
        send_random(70);
        settle();

        write_gain(16'h0000);
        send_random(60);
        settle();

        // The long result stall falls in this phase.
        write_gain(GAIN_W'($urandom));
        send_random(90);
        settle();

        write_gain(16'h1000);
        calm = 1'b1;
        send_random(60);

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("spectrum_band_mapper_tb: done, clean");
        end else begin
            $display("spectrum_band_mapper_tb: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
